// ----- hdl/gns_pkg.sv -----
// ----------------------------------------------------------------------------
// gns_pkg
// Shared types and constants of the 2D gradient noise sampler.
// ----------------------------------------------------------------------------
`default_nettype none

package gns_pkg;

  localparam int FRAC_W = 16;
  localparam int POS_W  = 32;
  localparam int CELL_W = 16;
  localparam int GRAD_W = 16;
  localparam int ENT_W  = 32;
  localparam int DOT_W  = 34;
  localparam int ACC_W  = 36;
  localparam int MUL_W  = 53;
  localparam int OUT_W  = 16;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SAMPLE = 1'b1
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE, S_MOD, S_ADJ, S_WR, S_RA, S_RB, S_RC,
    S_F1, S_F2, S_B1, S_B2, S_B3, S_B4, S_OUT
  } state_t;

endpackage

`default_nettype wire

// ----- hdl/gns_ram.sv -----
// ----------------------------------------------------------------------------
// gns_ram
// Generic RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module gns_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- hdl/gns_wrap.sv -----
// ----------------------------------------------------------------------------
// gns_wrap
// Modulo unit: reduces two 16-bit values modulo GRID_SIZE by reciprocal
// multiplication, in two pipelined stages; done pulses with valid remainders.
// ----------------------------------------------------------------------------
`default_nettype none

module gns_wrap #(
  parameter int GRID_SIZE = 256
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [gns_pkg::CELL_W-1:0]   a_in,
  input  wire logic [gns_pkg::CELL_W-1:0]   b_in,
  output logic                              done,
  output logic [$clog2(GRID_SIZE)-1:0]      a_rem,
  output logic [$clog2(GRID_SIZE)-1:0]      b_rem
);

  import gns_pkg::*;

  localparam int CW = $clog2(GRID_SIZE);
  localparam int SH = CELL_W + CW;
  localparam int MW = CELL_W + 2;
  localparam int PW = CELL_W + MW;
  localparam logic [MW-1:0] RECIP =
    MW'(((64'd1 << SH) + 64'(GRID_SIZE) - 64'd1) / 64'(GRID_SIZE));

  logic [CELL_W-1:0] a_r, b_r, qa_r, qb_r, qa_nxt, qb_nxt;
  logic [CW-1:0]     ra_r, rb_r, ra_nxt, rb_nxt;
  logic              v1_r, v2_r, done_r;
  logic [PW-1:0]     pa, pb;

  // quotient = floor(a * ceil(2^SH / GRID_SIZE) / 2^SH), exact for 16-bit a
  always_comb begin
    pa = PW'(a_r) * PW'(RECIP);
    pb = PW'(b_r) * PW'(RECIP);
    qa_nxt = CELL_W'(pa >> SH);
    qb_nxt = CELL_W'(pb >> SH);
    ra_nxt = CW'(a_r - CELL_W'(qa_r * CELL_W'(GRID_SIZE)));
    rb_nxt = CW'(b_r - CELL_W'(qb_r * CELL_W'(GRID_SIZE)));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v1_r   <= start;
      v2_r   <= v1_r;
      done_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a_in;
      b_r <= b_in;
    end
    if (v1_r) begin
      qa_r <= qa_nxt;
      qb_r <= qb_nxt;
    end
    if (v2_r) begin
      ra_r <= ra_nxt;
      rb_r <= rb_nxt;
    end
  end

  assign done  = done_r;
  assign a_rem = ra_r;
  assign b_rem = rb_r;

endmodule

`default_nettype wire

// ----- hdl/gradient_noise_2d_sampler.sv -----
// ----------------------------------------------------------------------------
// gradient_noise_2d_sampler
// 2D gradient noise over a GRID_SIZE x GRID_SIZE store of gradients.
// ----------------------------------------------------------------------------
// One item at a time. A write item reduces column and row in the two-stage
// reciprocal modulo unit and registers them, then does one RAM write. A sample
// item reduces and adjusts the cell, does the four corner reads through the
// single RAM read port (address, data, sum), then the fade and two blend
// levels through registered multipliers, and last loads the output register.
// The result waits in the output register; the next item is taken while it
// waits, and a following sample holds in its last state until that register
// is free. Entries read before they were written give undefined results.
`default_nettype none

module gradient_noise_2d_sampler #(
  parameter int GRID_SIZE = 256
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              in_operation,
  input  wire logic signed [gns_pkg::POS_W-1:0]  in_x_pos,
  input  wire logic signed [gns_pkg::POS_W-1:0]  in_y_pos,
  input  wire logic [7:0]                        in_write_column,
  input  wire logic [7:0]                        in_write_row,
  input  wire logic signed [gns_pkg::GRAD_W-1:0] in_grad_x_value,
  input  wire logic signed [gns_pkg::GRAD_W-1:0] in_grad_y_value,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [gns_pkg::OUT_W-1:0]              out_noise_value
);

  import gns_pkg::*;

  localparam int CW    = $clog2(GRID_SIZE);
  localparam int DEPTH = GRID_SIZE * GRID_SIZE;
  localparam int AW    = $clog2(DEPTH);
  localparam int COFF  = 32768 % GRID_SIZE;

  state_t state_r, state_nxt;
  logic   wrap_start, wrap_done;

  logic              op_r;
  logic [FRAC_W-1:0] fx_r, fy_r;
  logic [ENT_W-1:0]  gw_r;
  logic [CW-1:0]     xa_r, ya_r, x1, y1, xs, ys, a_rem, b_rem, xadj, yadj;
  logic [1:0]        k_r;
  logic [31:0]       tx2_r, ty2_r, t3x_r, t3y_r;
  logic [19:0]       p16x_r, p16y_r;
  logic [16:0]       fu_r, fw_r;
  logic signed [32:0]      pgx_r, pgy_r;
  logic signed [DOT_W-1:0] dot_r [4];
  logic signed [MUL_W-1:0] m0_r, m1_r, m2_r;
  logic signed [ACC_W-1:0] l0_r, l1_r, v_r;
  logic [OUT_W-1:0]  out_r;
  logic              out_valid_r;
  logic              we;
  logic [AW-1:0]     addr;
  logic [ENT_W-1:0]  rdata;
  logic [CELL_W-1:0] wa_in, wb_in;
  logic signed [16:0] dx, dy;
  logic [47:0]       t3x_full, t3y_full;
  logic [37:0]       px, py;
  logic [51:0]       fxp, fyp;
  logic signed [ACC_W:0] s_sum;
  logic [OUT_W-1:0]  res;
  logic              accept, out_free;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);

  assign wa_in = (in_operation == OP_SAMPLE) ? (in_x_pos[POS_W-1:FRAC_W] ^ 16'h8000)
                                             : {8'd0, in_write_column};
  assign wb_in = (in_operation == OP_SAMPLE) ? (in_y_pos[POS_W-1:FRAC_W] ^ 16'h8000)
                                             : {8'd0, in_write_row};
  assign wrap_start = accept;

  gns_wrap #(.GRID_SIZE(GRID_SIZE)) u_wrap (
    .clk   (clk),
    .rst_n (rst_n),
    .start (wrap_start),
    .a_in  (wa_in),
    .b_in  (wb_in),
    .done  (wrap_done),
    .a_rem (a_rem),
    .b_rem (b_rem)
  );

  always_comb begin
    xadj = (a_rem >= CW'(COFF)) ? CW'(a_rem - CW'(COFF)) : CW'(a_rem + CW'(GRID_SIZE - COFF));
    yadj = (b_rem >= CW'(COFF)) ? CW'(b_rem - CW'(COFF)) : CW'(b_rem + CW'(GRID_SIZE - COFF));
    x1 = (xa_r == CW'(GRID_SIZE - 1)) ? '0 : CW'(xa_r + 1'b1);
    y1 = (ya_r == CW'(GRID_SIZE - 1)) ? '0 : CW'(ya_r + 1'b1);
    xs = k_r[0] ? x1 : xa_r;
    ys = k_r[1] ? y1 : ya_r;
    if (state_r == S_WR) begin
      addr = AW'(AW'(ya_r) * AW'(GRID_SIZE) + AW'(xa_r));
    end else begin
      addr = AW'(AW'(ys) * AW'(GRID_SIZE) + AW'(xs));
    end
    we = (state_r == S_WR);
    dx = $signed({k_r[0], fx_r});
    dy = $signed({k_r[1], fy_r});
  end

  gns_ram #(.WIDTH(ENT_W), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (addr),
    .wdata (gw_r),
    .raddr (addr),
    .rdata (rdata)
  );

  always_comb begin
    t3x_full = 48'(tx2_r) * 48'(fx_r);
    t3y_full = 48'(ty2_r) * 48'(fy_r);
    px = 38'(tx2_r) * 38'd6 - ((38'(fx_r) * 38'd15) << 16) + (38'd10 << 32);
    py = 38'(ty2_r) * 38'd6 - ((38'(fy_r) * 38'd15) << 16) + (38'd10 << 32);
    fxp = 52'(t3x_r) * 52'(p16x_r);
    fyp = 52'(t3y_r) * 52'(p16y_r);
    s_sum = (ACC_W+1)'(v_r) + ((ACC_W+1)'(1) <<< 30);
    if (s_sum <= 0) begin
      res = '0;
    end else if ((s_sum >>> 15) > (ACC_W+1)'(65535)) begin
      res = '1;
    end else begin
      res = s_sum[30:15];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (accept) state_nxt = S_MOD;
      S_MOD:  if (wrap_done) state_nxt = S_ADJ;
      S_ADJ:  state_nxt = (op_r == OP_SAMPLE) ? S_RA : S_WR;
      S_WR:   state_nxt = S_IDLE;
      S_RA:   state_nxt = S_RB;
      S_RB:   state_nxt = S_RC;
      S_RC:   state_nxt = (k_r == 2'd3) ? S_F1 : S_RA;
      S_F1:   state_nxt = S_F2;
      S_F2:   state_nxt = S_B1;
      S_B1:   state_nxt = S_B2;
      S_B2:   state_nxt = S_B3;
      S_B3:   state_nxt = S_B4;
      S_B4:   state_nxt = S_OUT;
      S_OUT:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      k_r         <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == S_ADJ) begin
        k_r <= '0;
      end else if (state_r == S_RC) begin
        k_r <= k_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r <= in_operation;
      fx_r <= in_x_pos[FRAC_W-1:0];
      fy_r <= in_y_pos[FRAC_W-1:0];
      gw_r <= {in_grad_y_value, in_grad_x_value};
    end
    if (state_r == S_ADJ) begin
      xa_r  <= (op_r == OP_SAMPLE) ? xadj : a_rem;
      ya_r  <= (op_r == OP_SAMPLE) ? yadj : b_rem;
      tx2_r <= 32'(fx_r) * 32'(fx_r);
      ty2_r <= 32'(fy_r) * 32'(fy_r);
    end
    if (state_r == S_RB) begin
      pgx_r <= 33'($signed(rdata[15:0])) * 33'(dx);
      pgy_r <= 33'($signed(rdata[31:16])) * 33'(dy);
    end
    if (state_r == S_RC) begin
      dot_r[k_r] <= DOT_W'(pgx_r) + DOT_W'(pgy_r);
    end
    if (state_r == S_F1) begin
      t3x_r  <= t3x_full[47:16];
      t3y_r  <= t3y_full[47:16];
      p16x_r <= px[35:16];
      p16y_r <= py[35:16];
    end
    if (state_r == S_F2) begin
      fu_r <= fxp[48:32];
      fw_r <= fyp[48:32];
    end
    if (state_r == S_B1) begin
      m0_r <= MUL_W'(DOT_W'(dot_r[1]) - DOT_W'(dot_r[0]) + 35'sd0)
              * MUL_W'($signed({1'b0, fu_r}));
      m1_r <= MUL_W'(DOT_W'(dot_r[3]) - DOT_W'(dot_r[2]) + 35'sd0)
              * MUL_W'($signed({1'b0, fu_r}));
    end
    if (state_r == S_B2) begin
      l0_r <= ACC_W'(dot_r[0]) + ACC_W'(m0_r >>> 16);
      l1_r <= ACC_W'(dot_r[2]) + ACC_W'(m1_r >>> 16);
    end
    if (state_r == S_B3) begin
      m2_r <= MUL_W'(l1_r - l0_r) * MUL_W'($signed({1'b0, fw_r}));
    end
    if (state_r == S_B4) begin
      v_r <= l0_r + ACC_W'(m2_r >>> 16);
    end
    if (state_r == S_OUT && out_free) begin
      out_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_noise_value = out_r;

  a_start_mod: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == S_MOD)
    else $error("accepted item did not start modulo unit");

  a_done_in_mod: assert property (@(posedge clk) disable iff (!rst_n)
    wrap_done |-> state_r == S_MOD)
    else $error("modulo done outside its wait state");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && out_free) |=> (out_valid_r && state_r == S_IDLE))
    else $error("result not delivered to output register");

  a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WR && out_free) |=> !out_valid_r)
    else $error("write item produced a result");

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives gradient writes and noise samples into the 2D gradient noise
// sampler, predicts each noise value from a local gradient table and checks
// every result in order. Samples only touch cells whose gradients were loaded.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module testbench;
  import gns_pkg::*;

  localparam int GRID = 256;
  localparam int N_RANDOM = 1130;
  localparam int WATCHDOG = 20000;
  localparam int DRAIN = 100;

  typedef struct {
    op_t         op;
    logic [31:0] x;
    logic [31:0] y;
    logic [7:0]  col;
    logic [7:0]  row;
    logic [15:0] gx;
    logic [15:0] gy;
    logic        has_exp;
    logic [15:0] exp_val;
  } item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_operation = 1'b0;
  logic signed [31:0] in_x_pos = '0;
  logic signed [31:0] in_y_pos = '0;
  logic [7:0] in_write_column = '0;
  logic [7:0] in_write_row = '0;
  logic signed [15:0] in_grad_x_value = '0;
  logic signed [15:0] in_grad_y_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [15:0] out_noise_value;

  logic [15:0] grad_x [GRID*GRID];
  logic [15:0] grad_y [GRID*GRID];
  bit          loaded [GRID*GRID];
  logic [15:0] noise_q[$];
  item_t       table_rows[$];
  int          errors = 0;
  int          idle_cycles = 0;
  bit          long_hold = 1'b0;

  gradient_noise_2d_sampler #(.GRID_SIZE(GRID)) DUT (.*);

  always #6 clk = ~clk;

  function automatic longint fade(longint t);
    longint t3, p;
    t3 = (t * t * t) >>> 16;
    p = 6 * t * t - 15 * t * 65536 + 10 * 64'sd4294967296;
    return (t3 * (p >>> 16)) >>> 32;
  endfunction

  function automatic longint corner_dot(int cx, int cy, longint dx, longint dy);
    longint gx, gy;
    gx = longint'($signed(grad_x[cy*GRID+cx]));
    gy = longint'($signed(grad_y[cy*GRID+cx]));
    return gx * dx + gy * dy;
  endfunction

  function automatic longint lerp_q30(longint a, longint b, longint f);
    return a + (((b - a) * f) >>> 16);
  endfunction

  function automatic logic [15:0] noise_at(logic [31:0] xp, logic [31:0] yp);
    longint fx, fy, u, w, v, s;
    int x0, y0, x1, y1;
    fx = xp[15:0];
    fy = yp[15:0];
    x0 = xp[23:16];
    y0 = yp[23:16];
    x1 = (x0 + 1) % GRID;
    y1 = (y0 + 1) % GRID;
    u = fade(fx);
    w = fade(fy);
    v = lerp_q30(lerp_q30(corner_dot(x0, y0, fx, fy), corner_dot(x1, y0, fx - 65536, fy), u),
                 lerp_q30(corner_dot(x0, y1, fx, fy - 65536),
                          corner_dot(x1, y1, fx - 65536, fy - 65536), u), w);
    s = v + 64'sd1073741824;
    if (s <= 0) return 16'h0;
    s = s >>> 15;
    return (s > 65535) ? 16'hFFFF : s[15:0];
  endfunction

  function automatic bit cell_ready(logic [31:0] xp, logic [31:0] yp);
    int x0, y0, x1, y1;
    x0 = xp[23:16];
    y0 = yp[23:16];
    x1 = (x0 + 1) % GRID;
    y1 = (y0 + 1) % GRID;
    return loaded[y0*GRID+x0] && loaded[y0*GRID+x1] && loaded[y1*GRID+x0] &&
           loaded[y1*GRID+x1];
  endfunction

  function automatic item_t wr_item(int c, int r, logic [15:0] gx, logic [15:0] gy);
    item_t it;
    it = '{OP_WRITE, 32'($urandom), 32'($urandom), c[7:0], r[7:0], gx, gy, 1'b0, '0};
    return it;
  endfunction

  function automatic item_t smp_item(logic [31:0] x, logic [31:0] y, bit he,
                                     logic [15:0] ev);
    item_t it;
    it = '{OP_SAMPLE, x, y, 8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
           he, ev};
    return it;
  endfunction

  task automatic send(item_t it);
    logic [15:0] pred;
    in_valid <= 1'b1;
    in_operation <= it.op;
    in_x_pos <= it.x;
    in_y_pos <= it.y;
    in_write_column <= it.col;
    in_write_row <= it.row;
    in_grad_x_value <= it.gx;
    in_grad_y_value <= it.gy;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (it.op == OP_WRITE) begin
      grad_x[it.row*GRID+it.col] = it.gx;
      grad_y[it.row*GRID+it.col] = it.gy;
      loaded[it.row*GRID+it.col] = 1'b1;
    end else begin
      pred = noise_at(it.x, it.y);
      if (it.has_exp && pred != it.exp_val) begin
        $error("table row noise_value expected %h predicted %h", it.exp_val, pred);
        errors++;
      end
      noise_q.push_back(it.has_exp ? it.exp_val : pred);
    end
  endtask

  task automatic gap();
    int n;
    n = $urandom_range(1, 6);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_grad();
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return 16'($urandom);
    if (k == 1) return 16'h4000;
    if (k == 2) return 16'hC000;
    return 16'($urandom_range(0, 32768) - 16384);
  endfunction

  function automatic logic [31:0] rand_pos(int cx, int cy, bit ycoord);
    logic [31:0] p;
    p = $urandom;
    p[23:16] = ycoord ? cy[7:0] : cx[7:0];
    return p;
  endfunction

  // receiver stall pattern, with one long hold-off
  initial begin
    @(posedge rst_n);
    while (1) begin
      @(posedge clk);
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        out_stall <= 1'b0;
        long_hold = 1'b0;
      end else if (($urandom_range(0, 99)) < 25) begin
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (noise_q.size() == 0) begin
        $error("noise_value unexpected result %h", out_noise_value);
        errors++;
      end else begin
        if (out_noise_value !== noise_q[0]) begin
          $error("noise_value expected %h actual %h", noise_q[0], out_noise_value);
          errors++;
        end
        void'(noise_q.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int c, r, burst;
    item_t it;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: cells 0,1 and 255 loaded, then corners, wraps and extremes
    table_rows.push_back(wr_item(0, 0, 16'h0000, 16'h0000));
    table_rows.push_back(wr_item(1, 0, 16'h0000, 16'h0000));
    table_rows.push_back(wr_item(0, 1, 16'h0000, 16'h0000));
    table_rows.push_back(wr_item(1, 1, 16'h0000, 16'h0000));
    table_rows.push_back(smp_item(32'h0000_0000, 32'h0000_0000, 1'b1, 16'h8000));
    table_rows.push_back(smp_item(32'h0000_8000, 32'h0000_8000, 1'b1, 16'h8000));
    table_rows.push_back(wr_item(0, 0, 16'h7FFF, 16'h7FFF));
    table_rows.push_back(smp_item(32'h0000_FFFF, 32'h0000_FFFF, 1'b0, '0));
    table_rows.push_back(wr_item(0, 0, 16'h8000, 16'h8000));
    table_rows.push_back(smp_item(32'h0000_FFFF, 32'h0000_FFFF, 1'b0, '0));
    table_rows.push_back(wr_item(255, 255, 16'h4000, 16'hC000));
    table_rows.push_back(wr_item(0, 255, 16'h3FFF, 16'hC001));
    table_rows.push_back(wr_item(255, 0, 16'hC000, 16'h4000));
    table_rows.push_back(wr_item(255, 1, 16'hC000, 16'hC000));
    table_rows.push_back(wr_item(0, 0, 16'h4000, 16'h4000));
    table_rows.push_back(smp_item(32'hFFFF_8000, 32'hFFFF_8000, 1'b0, '0));
    table_rows.push_back(smp_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, '0));
    table_rows.push_back(smp_item(32'h8000_0000, 32'h8000_0000, 1'b0, '0));
    table_rows.push_back(smp_item(32'hFFFF_0001, 32'h0000_0001, 1'b0, '0));
    table_rows.push_back(smp_item(32'h00FF_4000, 32'hFF00_C000, 1'b0, '0));
    foreach (table_rows[i]) begin
      send(table_rows[i]);
      if ($urandom_range(0, 3) == 0) gap();
    end

    // random: load a region, then mostly sample loaded cells
    for (int n = 0; n < N_RANDOM; ) begin
      burst = $urandom_range(1, 24);
      for (int b = 0; b < burst && n < N_RANDOM; b++, n++) begin
        c = $urandom_range(0, 255);
        r = $urandom_range(0, 255);
        if (n < 250 || $urandom_range(0, 3) == 0) begin
          if (n < 250) begin
            c = $urandom_range(0, 7);
            r = $urandom_range(0, 7);
          end
          send(wr_item(c, r, rand_grad(), rand_grad()));
        end else begin
          if ($urandom_range(0, 1)) begin
            c = $urandom_range(0, 6);
            r = $urandom_range(0, 6);
          end
          if (!cell_ready({8'h0, c[7:0], 16'h0}, {8'h0, r[7:0], 16'h0})) begin
            c = 0;
            r = 0;
          end
          it = smp_item(rand_pos(c, r, 1'b0), rand_pos(c, r, 1'b1), 1'b0, '0);
          send(it);
        end
        if (n == 400) long_hold = 1'b1;
        if (n == 700) begin
          in_valid <= 1'b0;
          while (noise_q.size() != 0) @(posedge clk);
        end
      end
      gap();
    end
    in_valid <= 1'b0;
    while (noise_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (errors == 0 && noise_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
